// File: hw/rtl/brc_pkg.sv
// Package for the bit range copy engine: store geometry, item structs,
// controller state and the command/status structs between control and datapath.
// No dependencies.
package brc_pkg;

    // Store geometry
    localparam int STORE_BYTES   = 256;
    localparam int BITS_PER_BYTE = 8;
    localparam int STORE_BITS    = STORE_BYTES * BITS_PER_BYTE;
    localparam int ADDR_W        = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    // Wide enough for start bit + bit count and for STORE_BITS itself
    localparam int SUM_W         = 17;

    // Operation codes
    typedef enum logic [1:0] {
        FUNC_WR_SRC = 2'd0,
        FUNC_WR_DST = 2'd1,
        FUNC_COPY   = 2'd2,
        FUNC_RD_DST = 2'd3
    } brc_func_t;

    // Input transaction
    typedef struct packed {
        brc_func_t   func;
        logic [7:0]  byte_addr;
        logic [7:0]  byte_data;
        logic [10:0] src_start_bit;
        logic [10:0] dst_start_bit;
        logic [11:0] bit_count;
    } brc_in_t;

    // Result transaction
    typedef struct packed {
        logic [7:0] read_data;
        logic       status;
    } brc_out_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_CP_RD,
        ST_CP_WR,
        ST_FINISH
    } brc_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch accepted item, clear result
        logic wr_src;    // direct source byte write
        logic wr_dst;    // direct destination byte write
        logic rd_dst;    // issue destination byte read
        logic cap_rd;    // capture destination read data
        logic set_err;   // flag refused copy
        logic chunk_rd;  // read both stores for the current chunk
        logic chunk_wr;  // write merged chunk, advance pointers
        logic out_load;  // move result to output register
    } brc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic zero_cnt;
        logic range_err;
        logic last_chunk;
    } brc_sts_t;

endpackage

// File: hw/rtl/brc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module brc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                         aclk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, held while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/brc_datapath.sv
// Datapath: source and destination stores, copy pointers, chunk merge logic,
// result and output registers. Depends on brc_pkg and brc_ram.
module brc_datapath (
    input  logic              aclk,
    input  brc_pkg::brc_in_t  s_data,
    input  brc_pkg::brc_cmd_t cmd,
    output brc_pkg::brc_sts_t sts,
    output brc_pkg::brc_out_t m_data
);

    brc_pkg::brc_in_t  item_reg;
    logic [10:0]       src_ptr_reg, src_ptr_next;
    logic [10:0]       dst_ptr_reg, dst_ptr_next;
    logic [11:0]       remain_reg, remain_next;
    brc_pkg::brc_out_t res_reg, res_next;
    brc_pkg::brc_out_t out_reg;

    logic [2:0] soff, doff;
    logic [3:0] room_src, room_dst, room, n;
    logic [7:0] mask, bits, merged;
    logic [7:0] src_dout, dst_dout;
    logic       in_inside, item_inside;

    logic                      src_we, dst_we, dst_re;
    logic [brc_pkg::ADDR_W-1:0] dst_wr_addr, dst_rd_addr;
    logic [7:0]                dst_wr_data;

    assign in_inside   = {1'b0, s_data.byte_addr} < 9'(brc_pkg::STORE_BYTES);
    assign item_inside = {1'b0, item_reg.byte_addr} < 9'(brc_pkg::STORE_BYTES);

    // Chunk size: bounded by both alignments and the bits left
    assign soff     = src_ptr_reg[2:0];
    assign doff     = dst_ptr_reg[2:0];
    assign room_src = 4'd8 - {1'b0, soff};
    assign room_dst = 4'd8 - {1'b0, doff};
    assign room     = (room_src < room_dst) ? room_src : room_dst;
    assign n        = (remain_reg < {8'd0, room}) ? remain_reg[3:0] : room;

    // Merge chunk bits into the destination byte
    assign mask   = 8'hFF >> (4'd8 - n);
    assign bits   = (src_dout >> soff) & mask;
    assign merged = (dst_dout & ~(mask << doff)) | (bits << doff);

    // Status to controller
    assign sts.zero_cnt   = (item_reg.bit_count == 12'd0);
    assign sts.range_err  =
        ((brc_pkg::SUM_W'(item_reg.src_start_bit) + brc_pkg::SUM_W'(item_reg.bit_count))
            > brc_pkg::SUM_W'(brc_pkg::STORE_BITS)) ||
        ((brc_pkg::SUM_W'(item_reg.dst_start_bit) + brc_pkg::SUM_W'(item_reg.bit_count))
            > brc_pkg::SUM_W'(brc_pkg::STORE_BITS));
    assign sts.last_chunk = (remain_reg == {8'd0, n});

    // Store port steering
    assign src_we      = cmd.wr_src && in_inside;
    assign dst_we      = (cmd.wr_dst && in_inside) || cmd.chunk_wr;
    assign dst_wr_addr = cmd.chunk_wr ? brc_pkg::ADDR_W'(dst_ptr_reg >> 3)
                                      : brc_pkg::ADDR_W'(s_data.byte_addr);
    assign dst_wr_data = cmd.chunk_wr ? merged : s_data.byte_data;
    assign dst_re      = cmd.rd_dst || cmd.chunk_rd;
    assign dst_rd_addr = cmd.chunk_rd ? brc_pkg::ADDR_W'(dst_ptr_reg >> 3)
                                      : brc_pkg::ADDR_W'(s_data.byte_addr);

    brc_ram #(.WIDTH(8), .DEPTH(brc_pkg::STORE_BYTES)) u_src_ram (
        .aclk    (aclk),
        .we      (src_we),
        .wr_addr (brc_pkg::ADDR_W'(s_data.byte_addr)),
        .wr_data (s_data.byte_data),
        .re      (cmd.chunk_rd),
        .rd_addr (brc_pkg::ADDR_W'(src_ptr_reg >> 3)),
        .rd_data (src_dout)
    );

    brc_ram #(.WIDTH(8), .DEPTH(brc_pkg::STORE_BYTES)) u_dst_ram (
        .aclk    (aclk),
        .we      (dst_we),
        .wr_addr (dst_wr_addr),
        .wr_data (dst_wr_data),
        .re      (dst_re),
        .rd_addr (dst_rd_addr),
        .rd_data (dst_dout)
    );

    // Pointer and result next values
    always_comb begin
        src_ptr_next = src_ptr_reg;
        dst_ptr_next = dst_ptr_reg;
        remain_next  = remain_reg;
        res_next     = res_reg;
        if (cmd.load) begin
            src_ptr_next = s_data.src_start_bit;
            dst_ptr_next = s_data.dst_start_bit;
            remain_next  = s_data.bit_count;
            res_next     = '0;
        end else if (cmd.chunk_wr) begin
            src_ptr_next = src_ptr_reg + 11'(n);
            dst_ptr_next = dst_ptr_reg + 11'(n);
            remain_next  = remain_reg - 12'(n);
        end
        if (cmd.cap_rd) begin
            res_next.read_data = item_inside ? dst_dout : 8'd0;
        end
        if (cmd.set_err) begin
            res_next.status = 1'b1;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        src_ptr_reg <= src_ptr_next;
        dst_ptr_reg <= dst_ptr_next;
        remain_reg  <= remain_next;
        res_reg     <= res_next;
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end

    assign m_data = out_reg;

endmodule

// File: hw/rtl/brc_ctrl.sv
// Controller: sequences write, read and chunked copy operations and owns the
// input ready and output valid. Depends on brc_pkg.
module brc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  brc_pkg::brc_func_t func,
    output logic               m_valid,
    input  logic               m_ready,
    input  brc_pkg::brc_sts_t  sts,
    output brc_pkg::brc_cmd_t  cmd
);

    brc_pkg::brc_state_t state_reg, state_next;
    logic                m_valid_reg, m_valid_next;

    // State and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= brc_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid_next = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        case (state_reg)
            brc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    case (func)
                        brc_pkg::FUNC_WR_SRC: begin
                            cmd.wr_src = 1'b1;
                            state_next = brc_pkg::ST_FINISH;
                        end
                        brc_pkg::FUNC_WR_DST: begin
                            cmd.wr_dst = 1'b1;
                            state_next = brc_pkg::ST_FINISH;
                        end
                        brc_pkg::FUNC_COPY: begin
                            state_next = brc_pkg::ST_CHECK;
                        end
                        default: begin
                            cmd.rd_dst = 1'b1;
                            state_next = brc_pkg::ST_READ;
                        end
                    endcase
                end
            end
            brc_pkg::ST_READ: begin
                cmd.cap_rd = 1'b1;
                state_next = brc_pkg::ST_FINISH;
            end
            brc_pkg::ST_CHECK: begin
                if (sts.zero_cnt) begin
                    state_next = brc_pkg::ST_FINISH;
                end else if (sts.range_err) begin
                    cmd.set_err = 1'b1;
                    state_next  = brc_pkg::ST_FINISH;
                end else begin
                    state_next = brc_pkg::ST_CP_RD;
                end
            end
            brc_pkg::ST_CP_RD: begin
                cmd.chunk_rd = 1'b1;
                state_next   = brc_pkg::ST_CP_WR;
            end
            brc_pkg::ST_CP_WR: begin
                cmd.chunk_wr = 1'b1;
                state_next   = sts.last_chunk ? brc_pkg::ST_FINISH : brc_pkg::ST_CP_RD;
            end
            brc_pkg::ST_FINISH: begin
                // Hand result over once the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = brc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = brc_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

// File: hw/rtl/bit_range_copy_engine_core.sv
// Top level of the bit range copy engine: joins controller and datapath.
// Depends on brc_pkg, brc_ctrl, brc_datapath (and brc_ram through it).
//
//  channel | ports                      | payload
//  --------+----------------------------+-------------------
//  input   | s_valid, s_ready, s_data   | brc_pkg::brc_in_t
//  result  | m_valid, m_ready, m_data   | brc_pkg::brc_out_t
//
// One transaction at a time. A byte write runs IDLE then FINISH, a read IDLE,
// READ, FINISH, a copy IDLE, CHECK, CP_RD and CP_WR per chunk, then FINISH. A
// chunk is a store read then a merge and write on the destination store, one
// chunk per aligned run of up to 8 bits. An aligned copy of all 2048 bits is 256
// chunks; the longest copy, 2047 bits at unequal source and destination offsets,
// is 511 chunks. aresetn clears the controller only; store contents stay undefined
// until written. A stalled result holds in the output register while the next
// transaction is accepted and worked; a further result waits in the controller.
module bit_range_copy_engine_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  brc_pkg::brc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output brc_pkg::brc_out_t m_data
);

    brc_pkg::brc_cmd_t cmd;
    brc_pkg::brc_sts_t sts;

    brc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .func    (s_data.func),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    brc_datapath u_dp (
        .aclk   (aclk),
        .s_data (s_data),
        .cmd    (cmd),
        .sts    (sts),
        .m_data (m_data)
    );

endmodule

// File: hw/rtl/brc_checker.sv
// Port-level checker for bit_range_copy_engine_core, attached by bind.
// Depends on brc_pkg.
module brc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input brc_pkg::brc_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input brc_pkg::brc_out_t m_data
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Stalled input holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input changed while stalled");

    // One transaction in work at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted back to back");

    // A refused copy never carries read data
    a_err_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status |-> m_data.read_data == 8'd0)
        else $error("error result with nonzero read data");

endmodule

bind bit_range_copy_engine_core brc_checker u_brc_checker (.*);

// File: tb/sv/tb.sv
// Self-checking testbench for bit_range_copy_engine_core: byte writes, destination reads
// and bit range copies, checked against a shadow copy of both byte stores.
// Depends on brc_pkg and the engine RTL; needs no files or arguments.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import brc_pkg::*;

    localparam int FILL_OPS     = 2 * STORE_BYTES;
    localparam int DIR_OPS      = 23;
    localparam int RAND_OPS     = 650;
    localparam int STALL_CYCLES = 250;
    localparam int STALL_AT     = 620;   // result count that starts the long hold-off
    localparam int CALM_FROM    = 300;   // random transactions sent without gaps
    localparam int CALM_TO      = 400;
    localparam int SINK_CALM_LO = 800;   // results taken without stalls
    localparam int SINK_CALM_HI = 900;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        brc_in_t  op;
        bit       typed;
        brc_out_t want;
    } dir_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    brc_in_t   s_data;
    logic      m_valid;
    logic      m_ready;
    brc_out_t  m_data;

    // Shadow stores and result bookkeeping
    bit [7:0]  shadow_src [STORE_BYTES];
    bit [7:0]  shadow_dst [STORE_BYTES];
    brc_out_t  awaited_results [$];
    bit        sender_calm;
    int        fail_count;
    int        result_count;
    int        write_count;
    int        read_count;
    int        copy_count;
    int        refused_count;

    bit_range_copy_engine_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #100ms;
        $display("bit_range_copy_engine_core test failed");
        $finish;
    end

    // Apply one transaction to the shadow stores and return its result
    function automatic brc_out_t apply_transaction(brc_in_t op);
        brc_out_t res;
        int       limit;
        int       src_bit;
        int       dst_bit;
        int       span;
        bit       inside_store;
        res          = '0;
        limit        = STORE_BYTES * BITS_PER_BYTE;
        src_bit      = int'(op.src_start_bit);
        dst_bit      = int'(op.dst_start_bit);
        span         = int'(op.bit_count);
        inside_store = int'(op.byte_addr) < STORE_BYTES;
        case (op.func)
            FUNC_WR_SRC: begin
                if (inside_store)
                    shadow_src[op.byte_addr] = op.byte_data;
            end
            FUNC_WR_DST: begin
                if (inside_store)
                    shadow_dst[op.byte_addr] = op.byte_data;
            end
            FUNC_COPY: begin
                // zero length is a no-op; past either end is refused untouched
                if (span != 0) begin
                    if (src_bit + span > limit || dst_bit + span > limit) begin
                        res.status = 1'b1;
                    end else begin
                        for (int i = 0; i < span; i++)
                            shadow_dst[(dst_bit + i) / 8][(dst_bit + i) % 8] =
                                shadow_src[(src_bit + i) / 8][(src_bit + i) % 8];
                    end
                end
            end
            default: begin
                if (inside_store)
                    res.read_data = shadow_dst[op.byte_addr];
            end
        endcase
        return res;
    endfunction

    // Random payload, fields not used by the operation left random
    function automatic brc_in_t random_fields();
        logic [63:0] raw;
        brc_in_t     op;
        raw          = {$urandom, $urandom};
        op           = raw[$bits(brc_in_t)-1:0];
        op.bit_count = 12'($urandom_range(STORE_BITS));
        return op;
    endfunction

    function automatic brc_in_t random_transaction();
        brc_in_t op;
        int      pick;
        int      span;
        op   = random_fields();
        pick = $urandom_range(99);
        if (pick < 20) begin
            op.func = FUNC_WR_SRC;
        end else if (pick < 40) begin
            op.func = FUNC_WR_DST;
        end else if (pick < 62) begin
            op.func = FUNC_RD_DST;
        end else begin
            op.func = FUNC_COPY;
            pick    = $urandom_range(99);
            if (pick < 3)
                span = $urandom_range(STORE_BITS / 2, STORE_BITS);
            else if (pick < 8)
                span = 0;
            else if (pick < 20)
                span = $urandom_range(2, STORE_BITS);
            else
                span = $urandom_range(1, 48);
            op.bit_count = 12'(span);
            if (pick >= 8 && pick < 20) begin
                // overrun on one side, the other side arbitrary
                if ($urandom_range(1))
                    op.src_start_bit = 11'($urandom_range(STORE_BITS - span + 1, STORE_BITS - 1));
                else
                    op.dst_start_bit = 11'($urandom_range(STORE_BITS - span + 1, STORE_BITS - 1));
            end else if (span != 0) begin
                op.src_start_bit = 11'($urandom_range(0, STORE_BITS - span));
                op.dst_start_bit = 11'($urandom_range(0, STORE_BITS - span));
            end
        end
        return op;
    endfunction

    function automatic dir_row_t dir_row(brc_func_t f, int addr, int data, int src, int dst,
                                         int cnt, bit typed, int rd, bit st);
        dir_row_t row;
        row.op.func           = f;
        row.op.byte_addr      = 8'(addr);
        row.op.byte_data      = 8'(data);
        row.op.src_start_bit  = 11'(src);
        row.op.dst_start_bit  = 11'(dst);
        row.op.bit_count      = 12'(cnt);
        row.typed             = typed;
        row.want.read_data    = 8'(rd);
        row.want.status       = st;
        return row;
    endfunction

    // Offer one transaction, with random gaps, and log its expected result on acceptance
    task automatic send_transaction(input brc_in_t op, input bit typed, input brc_out_t want);
        brc_out_t predicted;
        while (!sender_calm && $urandom_range(99) < 27) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= op;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_transaction(op);
        awaited_results.push_back(typed ? want : predicted);
        case (op.func)
            FUNC_COPY: begin
                copy_count++;
                if (predicted.status)
                    refused_count++;
            end
            FUNC_RD_DST: read_count++;
            default:     write_count++;
        endcase
    endtask

    // Result side: check against the oldest expectation, random stalls and one long hold-off
    initial begin : result_sink
        int       hold_left;
        bit       held;
        brc_out_t want;
        hold_left = 0;
        held      = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                result_count++;
                if (awaited_results.size() == 0) begin
                    $error("unexpected result transaction: read_data %0h status %0b",
                           m_data.read_data, m_data.status);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_data.read_data !== want.read_data) begin
                        $error("read_data: expected %0h, actual %0h",
                               want.read_data, m_data.read_data);
                        fail_count++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0b, actual %0b", want.status, m_data.status);
                        fail_count++;
                    end
                end
                if (!held && result_count == STALL_AT) begin
                    held      = 1'b1;
                    hold_left = STALL_CYCLES;
                end
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (result_count >= SINK_CALM_LO && result_count < SINK_CALM_HI) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 27);
            end
        end
    end

    initial begin : stimulus
        dir_row_t dir_rows [DIR_OPS];
        brc_in_t  op;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        sender_calm = 1'b0;
        fail_count  = 0;

        // Directed rows; a typed expectation only where it is obvious
        dir_rows = '{
            dir_row(FUNC_WR_DST, 0,   'hA5, 0,    0,    0,    1, 0,    0),
            dir_row(FUNC_RD_DST, 0,   0,    0,    0,    0,    1, 'hA5, 0),
            dir_row(FUNC_WR_DST, 255, 'hFF, 0,    0,    0,    1, 0,    0),
            dir_row(FUNC_RD_DST, 255, 0,    0,    0,    0,    1, 'hFF, 0),
            dir_row(FUNC_WR_SRC, 0,   'h00, 0,    0,    0,    1, 0,    0),
            dir_row(FUNC_WR_SRC, 255, 'h80, 0,    0,    0,    1, 0,    0),
            dir_row(FUNC_COPY,   0,   0,    2047, 0,    1,    0, 0,    0),
            dir_row(FUNC_RD_DST, 0,   0,    0,    0,    0,    0, 0,    0),
            dir_row(FUNC_COPY,   0,   0,    2047, 2047, 0,    1, 0,    0),
            dir_row(FUNC_COPY,   0,   0,    2047, 0,    2,    1, 0,    1),
            dir_row(FUNC_COPY,   0,   0,    0,    2047, 2,    1, 0,    1),
            dir_row(FUNC_COPY,   0,   0,    1,    0,    2048, 1, 0,    1),
            dir_row(FUNC_COPY,   0,   0,    0,    0,    2048, 1, 0,    0),
            dir_row(FUNC_RD_DST, 255, 0,    0,    0,    0,    0, 0,    0),
            dir_row(FUNC_WR_DST, 128, 'h3C, 0,    0,    0,    1, 0,    0),
            dir_row(FUNC_COPY,   0,   0,    1,    0,    2047, 0, 0,    0),
            dir_row(FUNC_COPY,   0,   0,    0,    1,    2047, 0, 0,    0),
            dir_row(FUNC_RD_DST, 128, 0,    0,    0,    0,    0, 0,    0),
            dir_row(FUNC_COPY,   0,   0,    3,    13,   20,   0, 0,    0),
            dir_row(FUNC_COPY,   0,   0,    2040, 2040, 8,    0, 0,    0),
            dir_row(FUNC_COPY,   0,   0,    1024, 7,    9,    0, 0,    0),
            dir_row(FUNC_RD_DST, 1,   0,    0,    0,    0,    0, 0,    0),
            dir_row(FUNC_RD_DST, 0,   0,    0,    0,    0,    0, 0,    0)
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Fill both stores so nothing undefined is ever read
        for (int i = 0; i < FILL_OPS; i++) begin
            op           = random_fields();
            op.byte_addr = 8'(i % STORE_BYTES);
            if (i < STORE_BYTES)
                op.func = FUNC_WR_SRC;
            else
                op.func = FUNC_WR_DST;
            send_transaction(op, 1'b0, '0);
        end

        foreach (dir_rows[i])
            send_transaction(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].want);

        for (int i = 0; i < RAND_OPS; i++) begin
            sender_calm = (i >= CALM_FROM && i < CALM_TO);
            send_transaction(random_transaction(), 1'b0, '0);
        end
        sender_calm = 1'b0;
        s_valid <= 1'b0;

        // Drain, then stay idle a while longer to catch stray results
        while (awaited_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d transactions: %0d byte writes, %0d destination reads,",
                 write_count + read_count + copy_count, write_count, read_count);
        $display("%0d bit copies (%0d refused), with a %0d-cycle result hold-off.",
                 copy_count, refused_count, STALL_CYCLES);
        if (fail_count == 0 && awaited_results.size() == 0) begin
            $display("bit_range_copy_engine_core test passed");
        end else begin
            $display("bit_range_copy_engine_core test failed");
        end
        $finish;
    end

endmodule
